>>> rtl/core/assert_macros.svh
// assertion helpers used by compact_int_decoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CID_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// next-cycle implication
`define CID_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

>>> rtl/core/cid_pkg.sv
package cid_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	// encoded lengths in bytes
	localparam logic [2:0] LEN_1 = 3'd1;
	localparam logic [2:0] LEN_2 = 3'd2;
	localparam logic [2:0] LEN_4 = 3'd4;
	localparam logic [2:0] LEN_5 = 3'd5;

	// signed prefixes, upper nibble of the first byte
	localparam logic [3:0] SGN_FULL_NEG = 4'hF;
	localparam logic [3:0] SGN_FULL_POS = 4'hE;
	localparam logic [3:0] SGN_WORD_NEG = 4'hD;
	localparam logic [3:0] SGN_WORD_POS = 4'hC;

	// unsigned prefixes, upper three bits of the first byte
	localparam logic [2:0] UNS_FULL = 3'b111;
	localparam logic [2:0] UNS_WORD = 3'b110;

	typedef struct packed {
		logic [31:0] magnitude;
		logic        negate;
		logic [2:0]  length;
	} cid_entry_t;

	typedef struct packed {
		logic       valid;
		cid_entry_t entry;
	} cid_push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} cid_qstat_t;

endpackage

>>> rtl/core/cid_in_if.sv
interface cid_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       signed_kind;

	modport source (output valid, output data_byte, output signed_kind, input ready);
	modport sink (input valid, input data_byte, input signed_kind, output ready);
endinterface

>>> rtl/core/cid_out_if.sv
interface cid_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] value_bits;
	logic [2:0]  byte_count;

	modport source (output valid, output value_bits, output byte_count, input ready);
	modport sink (input valid, input value_bits, input byte_count, output ready);
endinterface

>>> rtl/core/cid_front.sv
module cid_front (
	input  logic               clk,
	input  logic               arst_n,
	cid_in_if.sink             din,
	input  cid_pkg::cid_qstat_t qstat,
	output cid_pkg::cid_push_t  push
);
	import cid_pkg::*;

	logic [2:0]  bytes_left_q;
	logic [31:0] partial_q;
	logic        negate_q;
	logic [2:0]  total_q;

	logic        accept;
	logic [7:0]  b;
	logic [2:0]  cls_len;
	logic [31:0] cls_mag;
	logic        cls_neg;
	logic [31:0] shifted;

	assign din.ready = !qstat.full;
	assign accept    = din.valid && din.ready;
	assign b         = din.data_byte;
	assign shifted   = {partial_q[23:0], b};

	// first-byte classification
	always_comb begin
		cls_len = LEN_1;
		cls_mag = '0;
		cls_neg = 1'b0;
		if (din.signed_kind) begin
			case (b[7:4]) inside
				SGN_FULL_POS, SGN_FULL_NEG: begin
					cls_len = LEN_5;
					cls_mag = '0;
					cls_neg = b[4];
				end
				SGN_WORD_POS, SGN_WORD_NEG: begin
					cls_len = LEN_4;
					cls_mag = {28'd0, b[3:0]};
					cls_neg = b[4];
				end
				default: begin
					if (b[7]) begin
						cls_len = LEN_2;
						cls_mag = {27'd0, b[4:0]};
						cls_neg = b[5];
					end else begin
						cls_len = LEN_1;
						cls_mag = {26'd0, b[5:0]};
						cls_neg = b[6];
					end
				end
			endcase
		end else begin
			case (b[7:5]) inside
				UNS_FULL: begin
					cls_len = LEN_5;
					cls_mag = '0;
				end
				UNS_WORD: begin
					cls_len = LEN_4;
					cls_mag = {27'd0, b[4:0]};
				end
				default: begin
					if (b[7]) begin
						cls_len = LEN_2;
						cls_mag = {26'd0, b[5:0]};
					end else begin
						cls_len = LEN_1;
						cls_mag = {24'd0, b};
					end
				end
			endcase
		end
	end

	always_comb begin
		push = '0;
		if (bytes_left_q != 3'd0) begin
			push.valid            = accept && (bytes_left_q == 3'd1);
			push.entry.magnitude  = shifted;
			push.entry.negate     = negate_q;
			push.entry.length     = total_q;
		end else begin
			push.valid            = accept && (cls_len == LEN_1);
			push.entry.magnitude  = cls_mag;
			push.entry.negate     = cls_neg;
			push.entry.length     = cls_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			negate_q     <= 1'b0;
			total_q      <= '0;
		end else if (accept) begin
			if (bytes_left_q != 3'd0) begin
				bytes_left_q <= bytes_left_q - 3'd1;
			end else begin
				bytes_left_q <= cls_len - 3'd1;
				negate_q     <= cls_neg;
				total_q      <= cls_len;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			partial_q <= (bytes_left_q != 3'd0) ? shifted : cls_mag;
		end
	end

endmodule

>>> rtl/core/cid_queue.sv
module cid_queue #(
	parameter int unsigned Depth = cid_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cid_pkg::cid_push_t  push,
	input  logic                pop,
	output cid_pkg::cid_entry_t head,
	output cid_pkg::cid_qstat_t qstat
);
	import cid_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

	cid_entry_t            entries_q [Depth];
	logic [PtrW-1:0]       wr_ptr_q;
	logic [PtrW-1:0]       rd_ptr_q;
	logic [CntW-1:0]       count_q;
	logic                  do_push;
	logic                  do_pop;

	assign qstat.full  = (count_q == CntW'(Depth));
	assign qstat.empty = (count_q == '0);
	assign do_push     = push.valid && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push.entry;
		end
	end

endmodule

>>> rtl/core/cid_back.sv
module cid_back (
	input  logic                clk,
	input  logic                arst_n,
	input  cid_pkg::cid_entry_t head,
	input  cid_pkg::cid_qstat_t qstat,
	output logic                pop,
	cid_out_if.source           dout
);
	import cid_pkg::*;

	logic        valid_q;
	logic [31:0] value_q;
	logic [2:0]  count_q;
	logic [31:0] result;

	assign result = head.negate ? (32'd0 - head.magnitude) : head.magnitude;
	assign pop    = !qstat.empty && (!valid_q || dout.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || dout.ready) begin
			valid_q <= !qstat.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			value_q <= result;
			count_q <= head.length;
		end
	end

	assign dout.valid      = valid_q;
	assign dout.value_bits = value_q;
	assign dout.byte_count = count_q;

endmodule

>>> rtl/core/compact_int_decoder.sv
// compact_int_decoder: prefix-coded 32-bit integer decoder
//
// din carries one byte of the stream per request (data_byte) and the coding
// of the value (signed_kind), looked at only on a value's first byte. dout
// carries one request per finished value: value_bits in two's complement and
// byte_count, the 1, 2, 4 or 5 bytes that the value used.
// Both channels use valid/ready; a request moves when both are high.
// Throughput: one byte per cycle while the queue is not full, set by the byte
// assembler in the front end. The edge that takes a value's last byte writes
// it into the queue; from there it is loaded into the output register once
// that register is empty or dout.ready is high.
// Reset clears the assembler, the queue and the output valid; the block takes
// bytes as soon as reset is released.
// When dout stalls, finished values collect in the queue (QueueDepth entries)
// behind the output register; din.ready drops only while the queue is full.
`include "assert_macros.svh"

module compact_int_decoder #(
	parameter int unsigned QueueDepth = cid_pkg::QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	cid_in_if.sink    din,
	cid_out_if.source dout
);
	import cid_pkg::*;

	cid_push_t  push;
	cid_qstat_t qstat;
	cid_entry_t head;
	logic       pop;
	logic       len_ok;

	cid_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.qstat  (qstat),
		.push   (push)
	);

	cid_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	cid_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.dout   (dout)
	);

	assign len_ok = (dout.byte_count == LEN_1) || (dout.byte_count == LEN_2)
		|| (dout.byte_count == LEN_4) || (dout.byte_count == LEN_5);

	`CID_ASSERT_IMP(a_no_push_full, clk, arst_n, push.valid, !qstat.full)
	`CID_ASSERT_IMP(a_count_legal, clk, arst_n, dout.valid, len_ok)
	`CID_ASSERT_NXT(a_queue_drains, clk, arst_n, !qstat.empty && !dout.valid, dout.valid)

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import cid_pkg::*;

	typedef struct {
		logic [7:0] data_byte;
		logic       signed_kind;
		bit         drain_first;
	} byte_req_t;

	typedef struct {
		logic [31:0] value_bits;
		logic [2:0]  byte_count;
	} decoded_t;

	localparam int RANDOM_BYTES = 1950;
	localparam int TAIL_CYCLES = 8;

	logic clk;
	logic arst_n;

	cid_in_if  din_bus ();
	cid_out_if dout_bus ();

	compact_int_decoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_bus),
		.dout   (dout_bus)
	);

	byte_req_t byte_requests[$];
	decoded_t  pending_values[$];

	int bytes_sent;
	int phase_1_start;
	int phase_2_start;
	int mismatch_count;

	// decoder state as seen by the predictor
	logic [2:0]  remaining_bytes;
	logic [31:0] assembled_word;
	logic        negate_pending;
	logic [2:0]  value_length;

	always #10 clk = ~clk;

	function automatic int sender_idle_pct();
		if (bytes_sent < phase_1_start) return 17;
		if (bytes_sent < phase_2_start) return 54;
		return 0;
	endfunction

	function automatic int receiver_idle_pct();
		if (bytes_sent < phase_1_start) return 54;
		if (bytes_sent < phase_2_start) return 17;
		return 0;
	endfunction

	function automatic bit decode_byte(input logic [7:0] b, input logic kind,
			output logic [31:0] value, output logic [2:0] count);
		bit done;
		done = 1'b0;
		value = '0;
		count = '0;
		if (remaining_bytes != 0) begin
			assembled_word = {assembled_word[23:0], b};
			remaining_bytes = remaining_bytes - 3'd1;
			done = (remaining_bytes == 0);
		end else begin
			negate_pending = 1'b0;
			if (kind) begin
				if (b[7:4] == SGN_FULL_NEG || b[7:4] == SGN_FULL_POS) begin
					value_length = LEN_5;
					assembled_word = '0;
					negate_pending = (b[7:4] == SGN_FULL_NEG);
				end else if (b[7:4] == SGN_WORD_NEG || b[7:4] == SGN_WORD_POS) begin
					value_length = LEN_4;
					assembled_word = {28'd0, b[3:0]};
					negate_pending = (b[7:4] == SGN_WORD_NEG);
				end else if (b[7]) begin
					value_length = LEN_2;
					assembled_word = {27'd0, b[4:0]};
					negate_pending = b[5];
				end else begin
					value_length = LEN_1;
					assembled_word = {26'd0, b[5:0]};
					negate_pending = b[6];
				end
			end else begin
				if (b[7:5] == UNS_FULL) begin
					value_length = LEN_5;
					assembled_word = '0;
				end else if (b[7:5] == UNS_WORD) begin
					value_length = LEN_4;
					assembled_word = {27'd0, b[4:0]};
				end else if (b[7]) begin
					value_length = LEN_2;
					assembled_word = {26'd0, b[5:0]};
				end else begin
					value_length = LEN_1;
					assembled_word = {24'd0, b};
				end
			end
			if (value_length == LEN_1) done = 1'b1;
			else remaining_bytes = value_length - 3'd1;
		end
		if (done) begin
			value = negate_pending ? 32'd0 - assembled_word : assembled_word;
			count = value_length;
			remaining_bytes = '0;
			assembled_word = '0;
			negate_pending = 1'b0;
		end
		return done;
	endfunction

	// first byte carries the coding, the rest carry the opposite flag
	task automatic add_value(input logic kind, input logic [7:0] lead,
			input logic [31:0] tail, input int tail_len);
		byte_requests.push_back('{lead, kind, 1'b0});
		for (int i = tail_len - 1; i >= 0; i--) begin
			byte_requests.push_back('{tail[8*i +: 8], ~kind, 1'b0});
		end
	endtask

	task automatic report_mismatch(input string what, input decoded_t want,
			input decoded_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("mismatch (%s): expected value %h count %0d, got value %h count %0d",
				what, want.value_bits, want.byte_count, got.value_bits, got.byte_count);
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin : drive_bytes
		logic next_valid;
		byte_req_t req;
		if (!arst_n) begin
			din_bus.valid <= 1'b0;
			din_bus.data_byte <= '0;
			din_bus.signed_kind <= 1'b0;
		end else if (!din_bus.valid || din_bus.ready) begin
			next_valid = 1'b0;
			if (byte_requests.size() > 0
					&& $urandom_range(0, 99) >= sender_idle_pct()) begin
				if (byte_requests[0].drain_first
						&& (din_bus.valid || pending_values.size() > 0)) begin
					next_valid = 1'b0;
				end else begin
					req = byte_requests.pop_front();
					din_bus.data_byte <= req.data_byte;
					din_bus.signed_kind <= req.signed_kind;
					bytes_sent++;
					next_valid = 1'b1;
				end
			end
			din_bus.valid <= next_valid;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout_bus.ready <= 1'b0;
		end else begin
			dout_bus.ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
		end
	end

	// monitor
	always @(posedge clk) begin : watch_channels
		decoded_t got;
		decoded_t want;
		logic [31:0] value;
		logic [2:0]  count;
		if (arst_n) begin
			if (dout_bus.valid && dout_bus.ready) begin
				got = '{dout_bus.value_bits, dout_bus.byte_count};
				if (pending_values.size() == 0) begin
					report_mismatch("unexpected request", '{32'd0, 3'd0}, got);
				end else begin
					want = pending_values.pop_front();
					if (got.value_bits !== want.value_bits)
						report_mismatch("value_bits", want, got);
					else if (got.byte_count !== want.byte_count)
						report_mismatch("byte_count", want, got);
				end
			end
			if (din_bus.valid && din_bus.ready) begin
				if (decode_byte(din_bus.data_byte, din_bus.signed_kind, value, count))
					pending_values.push_back('{value, count});
			end
		end
	end

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		int directed_len;
		int r;
		logic [7:0] b;
		clk = 1'b0;
		arst_n = 1'b0;
		din_bus.valid = 1'b0;
		din_bus.data_byte = '0;
		din_bus.signed_kind = 1'b0;
		dout_bus.ready = 1'b0;
		bytes_sent = 0;
		mismatch_count = 0;
		remaining_bytes = '0;
		assembled_word = '0;
		negate_pending = 1'b0;
		value_length = '0;

		// unsigned extremes of each length, marker with low bits set
		add_value(1'b0, 8'h00, 32'h0, 0);
		add_value(1'b0, 8'h7F, 32'h0, 0);
		add_value(1'b0, 8'hBF, 32'hFF, 1);
		add_value(1'b0, 8'hDF, 32'hFFFFFF, 3);
		add_value(1'b0, 8'hEA, 32'h80000000, 4);
		// signed: negative zero, most negative word
		add_value(1'b1, 8'h40, 32'h0, 0);
		add_value(1'b1, 8'hA0, 32'h00, 1);
		add_value(1'b1, 8'hD3, 32'hFFFFFF, 3);
		add_value(1'b1, 8'hF7, 32'h80000000, 4);
		directed_len = byte_requests.size();
		phase_1_start = directed_len + RANDOM_BYTES / 3;
		phase_2_start = directed_len + 2 * RANDOM_BYTES / 3;

		for (int i = 0; i < RANDOM_BYTES; i++) begin
			r = $urandom_range(0, 7);
			if (r == 0) b = 8'h00;
			else if (r == 1) b = 8'hFF;
			else b = 8'($urandom());
			byte_requests.push_back('{b, 1'($urandom()), 1'b0});
		end
		byte_requests[directed_len].drain_first = 1'b1;
		byte_requests[phase_1_start].drain_first = 1'b1;
		byte_requests[phase_2_start].drain_first = 1'b1;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_requests.size() > 0 || din_bus.valid || pending_values.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_values.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
